/* rtl/core/ttpg_pkg.sv */
// shared types and constants of the timed toggle pattern generator
// no dependencies; imported by ttpg_phase_mem, timed_toggle_pattern_generator, ttpg_checker and tb
package ttpg_pkg;

	localparam int CHANNELS_DEF   = 8;
	localparam int MAX_PHASES_DEF = 64;
	localparam int TIME_W         = 32;
	localparam int LEVELS_W       = 8;
	localparam int POS_W          = 6;

	// item action codes
	typedef enum logic [2:0] {
		ACT_DEFINE = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_QRY_CH,
		ST_QRY_WALK,
		ST_MOVE,
		ST_INS_WR,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/ttpg_phase_mem.sv */
// phase length store: one write port, one read port with registered read data
// depends on ttpg_pkg
module ttpg_phase_mem
	import ttpg_pkg::*;
#(
	parameter int DEPTH  = CHANNELS_DEF * MAX_PHASES_DEF,
	parameter int ADDR_W = $clog2(CHANNELS_DEF * MAX_PHASES_DEF)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [TIME_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [TIME_W-1:0] rdata
);

	logic [TIME_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/timed_toggle_pattern_generator.sv */
// top level of the timed toggle pattern generator: channel registers and sequencer
// depends on ttpg_pkg and ttpg_phase_mem
//
// usage
//   the input channel (in_valid / in_ready) carries one item per transfer:
//   define a channel, append a phase length, insert after a list position,
//   delete at a position, or query all channel levels at a time. every item
//   gives exactly one result on the output channel (out_valid / out_ready):
//   accepted, plus levels for a query.
//   the block works on one item at a time; in_ready is high only while the
//   sequencer is idle. a finished result sits in the output register, so the
//   next item can be taken while that result still waits for the receiver.
//   an item passes the decode state, then: a query walks each channel's
//   list in the channel and walk states; an insert, or a delete that moves
//   entries, passes the move state, and an insert then writes the new length;
//   every item ends in the done state. the phase memory has a single read
//   port, so one phase length is read per cycle for a walk or a move; the
//   walk sums the lengths through one shared adder.
//   a stalled receiver holds the result; a finished item then waits in the
//   done state until the output register frees.
//   reset clears the channel registers (all channels disabled, empty lists);
//   the phase memory is not cleared since only written entries are read.
module timed_toggle_pattern_generator
	import ttpg_pkg::*;
#(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int MAX_PHASES = MAX_PHASES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          action,
	input  logic [2:0]          channel,
	input  logic [TIME_W-1:0]   start_time,
	input  logic [TIME_W-1:0]   first_length,
	input  logic                start_level,
	input  logic                clear_list,
	input  logic [POS_W-1:0]    position,
	input  logic [TIME_W-1:0]   segment_length,
	input  logic [TIME_W-1:0]   query_time,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                accepted,
	output logic [LEVELS_W-1:0] levels
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W  = $clog2(MAX_PHASES + 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int DEPTH  = CHANNELS * MAX_PHASES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// flat address of list entry i of channel c
	function automatic logic [ADDR_W-1:0] mem_addr(input logic [CH_W-1:0] c,
			input logic [CNT_W-1:0] i);
		return ADDR_W'(ADDR_W'(c) * ADDR_W'(MAX_PHASES) + ADDR_W'(i));
	endfunction

	state_t state_q, state_d;

	// latched item
	logic [2:0]        act_q;
	logic [2:0]        ch_q;
	logic [TIME_W-1:0] start_in_q;
	logic [TIME_W-1:0] first_in_q;
	logic              lvl_in_q;
	logic              clr_q;
	logic [POS_W-1:0]  pos_q;
	logic [TIME_W-1:0] seg_q;
	logic [TIME_W-1:0] qt_q;

	// per-channel registers
	logic              en_q        [CHANNELS];
	logic [TIME_W-1:0] start_q     [CHANNELS];
	logic [TIME_W-1:0] first_len_q [CHANNELS];
	logic              first_lvl_q [CHANNELS];
	logic [CNT_W-1:0]  count_q     [CHANNELS];

	// move engine for insert and delete
	logic [CNT_W-1:0] src_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] prev_q;
	logic             dir_up_q;
	logic             rd_more_q;
	logic             pend_q;

	// query walk
	logic [CH_W-1:0]     qch_q;
	logic [TIME_W-1:0]   total_q;
	logic                lvl_q;
	logic [CNT_W-1:0]    idx_q;
	logic [LEVELS_W-1:0] lv_q;
	logic                acc_q;

	// output register
	logic                out_valid_q;
	logic                accepted_q;
	logic [LEVELS_W-1:0] levels_q;

	// memory port
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [TIME_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [TIME_W-1:0] mem_rdata;

	// edit checks on the addressed channel
	logic             ch_ok;
	logic [CH_W-1:0]  ch_ix;
	logic             cur_en;
	logic [CNT_W-1:0] cur_cnt;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic             cnt_full;
	logic             pos_inner;
	logic             app_ok;
	logic             ins_ok;
	logic             del_ok;

	// query step signals
	logic [TIME_W-1:0] add_a;
	logic [TIME_W-1:0] add_b;
	logic [TIME_W-1:0] sum;
	logic              hit;
	logic              q_skip;
	logic              q_end;
	logic              q_bit;
	logic              q_last_ch;
	logic [CNT_W-1:0]  idx_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign levels    = levels_q;

	assign ch_ok     = (32'(ch_q) < CHANNELS);
	assign ch_ix     = ch_q[CH_W-1:0];
	assign cur_en    = ch_ok && en_q[ch_ix];
	assign cur_cnt   = count_q[ch_ix];
	assign pos_w     = CMP_W'(pos_q);
	assign cnt_w     = CMP_W'(cur_cnt);
	assign cnt_full  = (cur_cnt == CNT_W'(MAX_PHASES));
	assign pos_inner = ((pos_w + CMP_W'(1)) < cnt_w);
	assign app_ok    = cur_en && !cnt_full;
	assign ins_ok    = cur_en && !cnt_full && pos_inner;
	assign del_ok    = cur_en && (pos_w < cnt_w);

	// shared adder: start + first length on the channel step, total + length on the walk
	always_comb begin
		if (state_q == ST_QRY_WALK) begin
			add_a = total_q;
			add_b = mem_rdata;
		end else begin
			add_a = start_q[qch_q];
			add_b = first_len_q[qch_q];
		end
	end

	assign sum       = add_a + add_b;
	assign hit       = (sum >= qt_q);
	assign q_skip    = !en_q[qch_q] || (start_q[qch_q] > qt_q);
	assign idx_next  = idx_q + CNT_W'(1);
	assign q_last_ch = (qch_q == CH_W'(CHANNELS - 1));

	// does this cycle settle the level of the current channel, and to what
	always_comb begin
		q_end = 1'b0;
		q_bit = 1'b0;
		case (state_q)
			ST_QRY_CH: begin
				if (q_skip) begin
					q_end = 1'b1;
				end else if (hit) begin
					q_end = 1'b1;
					q_bit = first_lvl_q[qch_q];
				end else if (count_q[qch_q] == '0) begin
					q_end = 1'b1;
				end
			end
			ST_QRY_WALK: begin
				if (hit) begin
					q_end = 1'b1;
					q_bit = ~lvl_q;
				end else if (idx_next == count_q[qch_q]) begin
					// walked past the last phase
					q_end = 1'b1;
				end
			end
			default: begin
				q_end = 1'b0;
				q_bit = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (act_q)
					ACT_QUERY:  state_d = ST_QRY_CH;
					ACT_INSERT: state_d = ins_ok ? ST_MOVE : ST_DONE;
					ACT_DELETE: state_d = (del_ok && pos_inner) ? ST_MOVE : ST_DONE;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_QRY_CH, ST_QRY_WALK: begin
				if (q_end) begin
					state_d = q_last_ch ? ST_DONE : ST_QRY_CH;
				end else begin
					state_d = ST_QRY_WALK;
				end
			end
			ST_MOVE: begin
				if (!rd_more_q && pend_q) begin
					state_d = dir_up_q ? ST_INS_WR : ST_DONE;
				end
			end
			ST_INS_WR: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = seg_q;
		mem_raddr = '0;
		case (state_q)
			ST_DECODE: begin
				// append writes at the end of the list
				if (act_q == ACT_APPEND && app_ok) begin
					mem_we    = 1'b1;
					mem_waddr = mem_addr(ch_ix, cur_cnt);
				end
			end
			ST_QRY_CH: mem_raddr = mem_addr(qch_q, '0);
			ST_QRY_WALK: mem_raddr = mem_addr(qch_q, idx_next);
			ST_MOVE: begin
				mem_raddr = mem_addr(ch_ix, src_q);
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					mem_waddr = mem_addr(ch_ix, dir_up_q ? prev_q + CNT_W'(1)
							: prev_q - CNT_W'(1));
				end
			end
			ST_INS_WR: begin
				// new length goes right after the position
				mem_we    = 1'b1;
				mem_waddr = mem_addr(ch_ix, end_q);
			end
			default: begin
				mem_we    = 1'b0;
				mem_raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q      <= action;
			ch_q       <= channel;
			start_in_q <= start_time;
			first_in_q <= first_length;
			lvl_in_q   <= start_level;
			clr_q      <= clear_list;
			pos_q      <= position;
			seg_q      <= segment_length;
			qt_q       <= query_time;
		end
	end

	// channel registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				en_q[c]        <= 1'b0;
				start_q[c]     <= '0;
				first_len_q[c] <= '0;
				first_lvl_q[c] <= 1'b0;
				count_q[c]     <= '0;
			end
		end else if (state_q == ST_DECODE) begin
			case (act_q)
				ACT_DEFINE: begin
					if (ch_ok) begin
						en_q[ch_ix]        <= 1'b1;
						start_q[ch_ix]     <= start_in_q;
						first_len_q[ch_ix] <= first_in_q;
						first_lvl_q[ch_ix] <= lvl_in_q;
						if (clr_q) begin
							count_q[ch_ix] <= '0;
						end
					end
				end
				ACT_APPEND: begin
					if (app_ok) begin
						count_q[ch_ix] <= cur_cnt + CNT_W'(1);
					end
				end
				ACT_INSERT: begin
					if (ins_ok) begin
						count_q[ch_ix] <= cur_cnt + CNT_W'(1);
					end
				end
				ACT_DELETE: begin
					if (del_ok) begin
						count_q[ch_ix] <= cur_cnt - CNT_W'(1);
					end
				end
				default: begin
					en_q[ch_ix] <= en_q[ch_ix];
				end
			endcase
		end
	end

	// sequencer datapath: move engine, query walk, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_more_q <= 1'b0;
			pend_q    <= 1'b0;
			dir_up_q  <= 1'b0;
			src_q     <= '0;
			end_q     <= '0;
			prev_q    <= '0;
			total_q   <= '0;
			lvl_q     <= 1'b0;
			idx_q     <= '0;
			acc_q     <= 1'b0;
			lv_q      <= '0;
			qch_q     <= '0;
		end else begin
			case (state_q)
				ST_DECODE: begin
					lv_q      <= '0;
					qch_q     <= '0;
					pend_q    <= 1'b0;
					rd_more_q <= 1'b1;
					case (act_q)
						ACT_DEFINE: acc_q <= ch_ok;
						ACT_APPEND: acc_q <= app_ok;
						ACT_INSERT: begin
							acc_q    <= ins_ok;
							// copy from the end down to just past the position
							dir_up_q <= 1'b1;
							src_q    <= cur_cnt - CNT_W'(1);
							end_q    <= CNT_W'(pos_w + CMP_W'(1));
						end
						ACT_DELETE: begin
							acc_q    <= del_ok;
							// copy from just past the position up to the end
							dir_up_q <= 1'b0;
							src_q    <= CNT_W'(pos_w + CMP_W'(1));
							end_q    <= cur_cnt - CNT_W'(1);
						end
						ACT_QUERY: acc_q <= 1'b1;
						default:   acc_q <= 1'b0;
					endcase
				end
				ST_MOVE: begin
					if (rd_more_q) begin
						prev_q <= src_q;
						pend_q <= 1'b1;
						if (src_q == end_q) begin
							rd_more_q <= 1'b0;
						end else begin
							src_q <= dir_up_q ? src_q - CNT_W'(1) : src_q + CNT_W'(1);
						end
					end else begin
						pend_q <= 1'b0;
					end
				end
				ST_QRY_CH, ST_QRY_WALK: begin
					if (q_end) begin
						lv_q <= lv_q | (LEVELS_W'(q_bit) << qch_q);
						if (!q_last_ch) begin
							qch_q <= qch_q + CH_W'(1);
						end
					end else begin
						total_q <= sum;
						if (state_q == ST_QRY_CH) begin
							lvl_q <= first_lvl_q[qch_q];
							idx_q <= '0;
						end else begin
							lvl_q <= ~lvl_q;
							idx_q <= idx_next;
						end
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			accepted_q <= acc_q;
			levels_q   <= lv_q;
		end
	end

	ttpg_phase_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_phase_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* tb/ttpg_checker.sv */
`timescale 1ns / 100ps
// checker for the timed toggle pattern generator: watches both channels,
// predicts each result from its own copy of the channel state and compares; needs ttpg_pkg
module ttpg_checker
	import ttpg_pkg::*;
#(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int MAX_PHASES = MAX_PHASES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [2:0]          action,
	input  logic [2:0]          channel,
	input  logic [TIME_W-1:0]   start_time,
	input  logic [TIME_W-1:0]   first_length,
	input  logic                start_level,
	input  logic                clear_list,
	input  logic [POS_W-1:0]    position,
	input  logic [TIME_W-1:0]   segment_length,
	input  logic [TIME_W-1:0]   query_time,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                accepted,
	input  logic [LEVELS_W-1:0] levels,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic                acc;
		logic [LEVELS_W-1:0] lv;
	} result_t;

	logic              ch_on       [CHANNELS];
	logic [TIME_W-1:0] ch_start    [CHANNELS];
	logic [TIME_W-1:0] ch_first    [CHANNELS];
	logic              ch_first_lv [CHANNELS];
	int                ch_count    [CHANNELS];
	logic [TIME_W-1:0] ch_phase    [CHANNELS][MAX_PHASES];
	result_t           results_due [$];
	int                result_no;

	// level of one channel at time t, all sums wrap at the time width
	function automatic logic channel_level(int ch, logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] phase_end;
		logic              lvl;
		if (!ch_on[ch] || ch_start[ch] > t)
			return 1'b0;
		lvl = ch_first_lv[ch];
		phase_end = ch_start[ch] + ch_first[ch];
		if (phase_end >= t)
			return lvl;
		for (int i = 0; i < ch_count[ch]; i++) begin
			phase_end = phase_end + ch_phase[ch][i];
			lvl = ~lvl;
			if (phase_end >= t)
				return lvl;
		end
		return 1'b0;
	endfunction

	// carries out one item on the channel state and returns its result
	function automatic result_t apply_item(logic [2:0] act, int ch, logic [TIME_W-1:0] st,
			logic [TIME_W-1:0] fl, logic slev, logic clr, int p, logic [TIME_W-1:0] seg,
			logic [TIME_W-1:0] qt);
		result_t r;
		logic    editable;
		int      cnt;
		r = '0;
		editable = (ch < CHANNELS) && ch_on[ch];
		cnt = editable ? ch_count[ch] : 0;
		case (act)
			ACT_QUERY: begin
				r.acc = 1'b1;
				for (int c = 0; c < CHANNELS && c < LEVELS_W; c++)
					r.lv[c] = channel_level(c, qt);
			end
			ACT_DEFINE: begin
				if (ch < CHANNELS) begin
					ch_on[ch] = 1'b1;
					ch_start[ch] = st;
					ch_first[ch] = fl;
					ch_first_lv[ch] = slev;
					if (clr)
						ch_count[ch] = 0;
					r.acc = 1'b1;
				end
			end
			ACT_APPEND: begin
				if (editable && cnt < MAX_PHASES) begin
					ch_phase[ch][cnt] = seg;
					ch_count[ch] = cnt + 1;
					r.acc = 1'b1;
				end
			end
			ACT_INSERT: begin
				if (editable && cnt < MAX_PHASES && p + 1 < cnt) begin
					for (int i = cnt; i > p + 1; i--)
						ch_phase[ch][i] = ch_phase[ch][i-1];
					ch_phase[ch][p+1] = seg;
					ch_count[ch] = cnt + 1;
					r.acc = 1'b1;
				end
			end
			ACT_DELETE: begin
				if (editable && p < cnt) begin
					for (int i = p; i + 1 < cnt; i++)
						ch_phase[ch][i] = ch_phase[ch][i+1];
					ch_count[ch] = cnt - 1;
					r.acc = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: result %0d: %s", $time, result_no, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				ch_on[c] = 1'b0;
				ch_start[c] = '0;
				ch_first[c] = '0;
				ch_first_lv[c] = 1'b0;
				ch_count[c] = 0;
			end
			results_due.delete();
			result_no = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			// results leave before the new item is predicted
			if (out_valid && out_ready) begin
				got.acc = accepted;
				got.lv = levels;
				if (results_due.size() == 0) begin
					note_failure($sformatf("unexpected result accepted=%0b levels=%02h",
						got.acc, got.lv));
				end else begin
					want = results_due.pop_front();
					if (got.acc !== want.acc || got.lv !== want.lv)
						note_failure($sformatf(
							"expected accepted=%0b levels=%02h, got accepted=%0b levels=%02h",
							want.acc, want.lv, got.acc, got.lv));
				end
				result_no++;
			end
			if (in_valid && in_ready)
				results_due.push_back(apply_item(action, int'(channel), start_time,
					first_length, start_level, clear_list, int'(position), segment_length,
					query_time));
			pending = results_due.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// top of the timed toggle pattern generator testbench: clock, reset, stimulus, verdict
// depends on ttpg_pkg, timed_toggle_pattern_generator and ttpg_checker
module tb;
	import ttpg_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RANDOM_ITEMS = 1900;
	localparam int ACTION_CODES = 8;
	// longest single item: a query walking every channel's full list
	localparam int DRAIN_CYCLES = 3 + CHANNELS_DEF * (1 + MAX_PHASES_DEF) + 16;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b1;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic [2:0]          action         = ACT_QUERY;
	logic [2:0]          channel        = '0;
	logic [TIME_W-1:0]   start_time     = '0;
	logic [TIME_W-1:0]   first_length   = '0;
	logic                start_level    = 1'b0;
	logic                clear_list     = 1'b0;
	logic [POS_W-1:0]    position       = '0;
	logic [TIME_W-1:0]   segment_length = '0;
	logic [TIME_W-1:0]   query_time     = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic                accepted;
	logic [LEVELS_W-1:0] levels;

	// registered copy of the input handshake, read by the driver at the falling edge
	logic                in_xfer        = 1'b0;
	int unsigned         tx_idle_pct    = 38;
	int unsigned         rx_idle_pct    = 56;
	int                  fail_count;
	int                  pending;

	always #(HALF_PERIOD) clk = ~clk;

	timed_toggle_pattern_generator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.channel        (channel),
		.start_time     (start_time),
		.first_length   (first_length),
		.start_level    (start_level),
		.clear_list     (clear_list),
		.position       (position),
		.segment_length (segment_length),
		.query_time     (query_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.levels         (levels)
	);

	ttpg_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.channel        (channel),
		.start_time     (start_time),
		.first_length   (first_length),
		.start_level    (start_level),
		.clear_list     (clear_list),
		.position       (position),
		.segment_length (segment_length),
		.query_time     (query_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.levels         (levels),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always @(posedge clk) begin
		in_xfer <= in_valid && in_ready;
	end

	// receiver stalls at random, at the rate of the current phase
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// one input transfer; called at a falling edge and returns at the falling
	// edge right after the transfer, so valid stays up between back-to-back items
	task automatic send_item(logic [2:0] act, logic [2:0] ch, logic [TIME_W-1:0] st,
			logic [TIME_W-1:0] fl, logic slev, logic clr, logic [POS_W-1:0] p,
			logic [TIME_W-1:0] seg, logic [TIME_W-1:0] qt);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		action         <= act;
		channel        <= ch;
		start_time     <= st;
		first_length   <= fl;
		start_level    <= slev;
		clear_list     <= clr;
		position       <= p;
		segment_length <= seg;
		query_time     <= qt;
		in_valid       <= 1'b1;
		do
			@(negedge clk);
		while (!in_xfer);
	endtask

	// directed helpers; fields the action ignores carry random junk
	task automatic define_ch(logic [2:0] ch, logic [TIME_W-1:0] st, logic [TIME_W-1:0] fl,
			logic slev, logic clr);
		send_item(ACT_DEFINE, ch, st, fl, slev, clr, POS_W'($urandom), $urandom, $urandom);
	endtask

	task automatic edit_ch(logic [2:0] act, logic [2:0] ch, logic [POS_W-1:0] p,
			logic [TIME_W-1:0] seg);
		send_item(act, ch, $urandom, $urandom, 1'($urandom), 1'($urandom), p, seg,
			$urandom);
	endtask

	task automatic query_at(logic [TIME_W-1:0] qt);
		send_item(ACT_QUERY, 3'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom),
			POS_W'($urandom), $urandom, qt);
	endtask

	initial begin
		int unsigned pick;
		logic        wide;
		logic [2:0]  act;

		#1 arst_n <= 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// everything disabled after reset
		query_at('0);
		// edits on a channel that was never defined are refused
		edit_ch(ACT_APPEND, 3'd3, '0, 32'd5);
		edit_ch(ACT_INSERT, 3'd3, '0, 32'd5);
		edit_ch(ACT_DELETE, 3'd3, '0, '0);
		// channel 0: starts at 10, high through 15
		define_ch(3'd0, 32'd10, 32'd5, 1'b1, 1'b1);
		// insert and delete on an empty list
		edit_ch(ACT_INSERT, 3'd0, '0, 32'd7);
		edit_ch(ACT_DELETE, 3'd0, '0, '0);
		edit_ch(ACT_APPEND, 3'd0, '0, 32'd3);
		edit_ch(ACT_APPEND, 3'd0, '0, 32'd4);
		// insert after the last entry is refused, after the first one goes through
		edit_ch(ACT_INSERT, 3'd0, 6'd1, 32'd9);
		edit_ch(ACT_INSERT, 3'd0, 6'd0, 32'd2);
		// delete beyond the list, then the tail entry (nothing moves)
		edit_ch(ACT_DELETE, 3'd0, '1, '0);
		edit_ch(ACT_DELETE, 3'd0, 6'd2, '0);
		// phase edges: end of first phase, inside the list, past the last phase
		query_at(32'd15);
		query_at(32'd16);
		query_at(32'd20);
		query_at(32'd21);
		// start near the top with the longest first phase: the end time wraps
		define_ch(3'd7, 32'hFFFF_FFF0, '1, 1'b0, 1'b0);
		query_at('1);
		// redefine without clearing keeps the list
		define_ch(3'd0, 32'd10, 32'd5, 1'b0, 1'b0);
		query_at(32'd16);
		// zero-length phases and the largest segment
		define_ch(3'd1, '0, '0, 1'b1, 1'b1);
		edit_ch(ACT_APPEND, 3'd1, '0, '1);
		query_at('0);
		// undefined action codes do nothing
		for (int a = ACT_QUERY + 1; a < ACTION_CODES; a++)
			edit_ch(3'(a), 3'($urandom), POS_W'($urandom), $urandom);

		// random part: mostly small times so queries land inside the lists, rare
		// clears so lists fill up to the limit, now and then full-range values
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				tx_idle_pct = 56;
				rx_idle_pct = 38;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			pick = $urandom_range(99);
			wide = ($urandom_range(9) == 0);
			if (pick < 8)
				act = ACT_DEFINE;
			else if (pick < 43)
				act = ACT_APPEND;
			else if (pick < 58)
				act = ACT_INSERT;
			else if (pick < 70)
				act = ACT_DELETE;
			else if (pick < 97)
				act = ACT_QUERY;
			else
				act = 3'($urandom_range(ACT_QUERY + 1, ACTION_CODES - 1));
			send_item(act, 3'($urandom_range(CHANNELS_DEF - 1)),
				wide ? $urandom : $urandom_range(200),
				wide ? $urandom : $urandom_range(40),
				1'($urandom_range(1)),
				($urandom_range(9) == 0),
				POS_W'($urandom_range((1 << POS_W) - 1)),
				wide ? $urandom : $urandom_range(16),
				wide ? $urandom : $urandom_range(1200));
		end
		in_valid <= 1'b0;

		// drain: every expected result back, then room for a stray one
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog: several times the slowest legal run (all queries walking full lists)
	initial begin
		#25_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
